### hw/rtl/stcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stcp_pkg: shared types and constants for temperature/pressure compensation
// Coefficient and result records, register indexes, fixed constants and
// helper functions for sign and zero extension and arithmetic shift.
// ----------------------------------------------------------------------------
package stcp_pkg;

	localparam int DataW    = 32;
	localparam int AdcW     = 20;
	localparam int CoefW    = 16;
	localparam int CfgW     = 48;
	localparam int CfgIdxW  = 3;
	localparam int NumRegs  = 4;
	localparam int InDataW  = 24;
	localparam int OutDataW = 64;

	localparam logic [CfgIdxW-1:0] REG_TEMP    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_PRESS_A = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_PRESS_B = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_PRESS_C = 3'd3;

	localparam logic KIND_TEMP  = 1'b0;
	localparam logic KIND_PRESS = 1'b1;

	localparam logic [DataW-1:0] FINE_OFS    = 32'd64000;
	localparam logic [DataW-1:0] ADC_FULL    = 32'd1048576;
	localparam logic [DataW-1:0] PRESS_SCALE = 32'd3125;
	localparam logic [DataW-1:0] P1_BIAS     = 32'd32768;
	localparam logic [DataW-1:0] TEMP_ROUND  = 32'd128;
	localparam logic [DataW-1:0] TEMP_MUL    = 32'd5;

	typedef struct packed {
		logic [CoefW-1:0] t1;
		logic [CoefW-1:0] t2;
		logic [CoefW-1:0] t3;
		logic [CoefW-1:0] p1;
		logic [CoefW-1:0] p2;
		logic [CoefW-1:0] p3;
		logic [CoefW-1:0] p4;
		logic [CoefW-1:0] p5;
		logic [CoefW-1:0] p6;
		logic [CoefW-1:0] p7;
		logic [CoefW-1:0] p8;
		logic [CoefW-1:0] p9;
	} stcp_coef_t;

	typedef struct packed {
		logic             kind;
		logic [DataW-1:0] temp;
		logic [DataW-1:0] press;
	} stcp_res_t;

	function automatic logic [DataW-1:0] sext16(input logic [CoefW-1:0] f);
		return {{(DataW-CoefW){f[CoefW-1]}}, f};
	endfunction

	function automatic logic [DataW-1:0] zext16(input logic [CoefW-1:0] f);
		return {{(DataW-CoefW){1'b0}}, f};
	endfunction

	function automatic logic [DataW-1:0] sra32(input logic [DataW-1:0] x, input int unsigned n);
		return DataW'($signed(x) >>> n);
	endfunction

endpackage
`default_nettype wire

### hw/rtl/stcp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stcp_div: serial unsigned divider
// Restoring division, one quotient bit per cycle, done pulse after the last.
// ----------------------------------------------------------------------------
module stcp_div
	import stcp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DataW-1:0] dividend,
	input  logic [DataW-1:0] divisor,
	output logic             done,
	output logic [DataW-1:0] quot
);

	localparam int CntW = $clog2(DataW);
	localparam logic [CntW-1:0] LastCnt = CntW'(DataW - 1);

	logic            busy_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [DataW-1:0] rem_q;
	logic [DataW-1:0] quo_q;
	logic [DataW-1:0] den_q;
	logic [DataW:0]   shifted;
	logic [DataW:0]   diff;

	assign shifted = {rem_q, quo_q[DataW-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CntW'(1);
				if (cnt_q == LastCnt) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DataW]) begin
				rem_q <= diff[DataW-1:0];
				quo_q <= {quo_q[DataW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DataW-1:0];
				quo_q <= {quo_q[DataW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule
`default_nettype wire

### hw/rtl/stcp_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stcp_core: compensation sequencer
// One shared 32-bit multiplier and a scratch register set stepped by a
// one-hot sequencer; the pressure path hands its division to stcp_div.
// ----------------------------------------------------------------------------
module stcp_core
	import stcp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            req_type,
	input  logic [AdcW-1:0] raw_adc,
	input  stcp_coef_t      coef,
	input  logic            out_free,
	output logic            idle,
	output logic            push,
	output stcp_res_t       res
);

	typedef enum logic [27:0] {
		ST_IDLE = 28'b1 << 0,
		ST_T0   = 28'b1 << 1,
		ST_T1   = 28'b1 << 2,
		ST_T2   = 28'b1 << 3,
		ST_T3   = 28'b1 << 4,
		ST_T4   = 28'b1 << 5,
		ST_T5   = 28'b1 << 6,
		ST_T6   = 28'b1 << 7,
		ST_P0   = 28'b1 << 8,
		ST_P1   = 28'b1 << 9,
		ST_P2   = 28'b1 << 10,
		ST_P3   = 28'b1 << 11,
		ST_P4   = 28'b1 << 12,
		ST_P5   = 28'b1 << 13,
		ST_P6   = 28'b1 << 14,
		ST_P7   = 28'b1 << 15,
		ST_P8   = 28'b1 << 16,
		ST_P9   = 28'b1 << 17,
		ST_P10  = 28'b1 << 18,
		ST_P11  = 28'b1 << 19,
		ST_P12  = 28'b1 << 20,
		ST_P13  = 28'b1 << 21,
		ST_P14  = 28'b1 << 22,
		ST_P15  = 28'b1 << 23,
		ST_P16  = 28'b1 << 24,
		ST_P17  = 28'b1 << 25,
		ST_P18  = 28'b1 << 26,
		ST_DONE = 28'b1 << 27
	} stcp_state_t;

	stcp_state_t state_q, state_d;

	logic [DataW-1:0] fine_q;
	logic [AdcW-1:0]  adc_q;
	logic [DataW-1:0] a_q, b_q, c_q, d_q, e_q, p_q;
	logic             big_q;
	stcp_res_t        res_q;

	logic [DataW-1:0] mul_a, mul_b, mul_y;
	logic [DataW-1:0] adc_x;
	logic             div_start, div_done;
	logic [DataW-1:0] div_dividend, div_quot;

	assign adc_x = {{(DataW-AdcW){1'b0}}, adc_q};
	assign mul_y = mul_a * mul_b;

	assign div_start    = (state_q == ST_P12);
	assign div_dividend = p_q[DataW-1] ? p_q : (p_q << 1);

	stcp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (a_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			ST_IDLE: if (start) state_d = req_type ? ST_P0 : ST_T0;
			ST_T0:   state_d = ST_T1;
			ST_T1: begin
				mul_a   = a_q;
				mul_b   = sext16(coef.t2);
				state_d = ST_T2;
			end
			ST_T2: begin
				mul_a   = b_q;
				mul_b   = b_q;
				state_d = ST_T3;
			end
			ST_T3: begin
				mul_a   = sra32(p_q, 12);
				mul_b   = sext16(coef.t3);
				state_d = ST_T4;
			end
			ST_T4:   state_d = ST_T5;
			ST_T5: begin
				mul_a   = fine_q;
				mul_b   = TEMP_MUL;
				state_d = ST_T6;
			end
			ST_T6:   state_d = ST_DONE;
			ST_P0:   state_d = ST_P1;
			ST_P1:   state_d = ST_P2;
			ST_P2: begin
				mul_a   = b_q;
				mul_b   = b_q;
				state_d = ST_P3;
			end
			ST_P3: begin
				mul_a   = a_q;
				mul_b   = sext16(coef.p5);
				state_d = ST_P4;
			end
			ST_P4: begin
				mul_a   = c_q;
				mul_b   = sext16(coef.p6);
				state_d = ST_P5;
			end
			ST_P5: begin
				mul_a   = sext16(coef.p3);
				mul_b   = d_q;
				state_d = ST_P6;
			end
			ST_P6: begin
				mul_a   = sext16(coef.p2);
				mul_b   = a_q;
				state_d = ST_P7;
			end
			ST_P7:   state_d = ST_P8;
			ST_P8: begin
				mul_a   = P1_BIAS + a_q;
				mul_b   = zext16(coef.p1);
				state_d = ST_P9;
			end
			ST_P9:   state_d = ST_P10;
			ST_P10:  state_d = (a_q == '0) ? ST_DONE : ST_P11;
			ST_P11: begin
				mul_a   = c_q;
				mul_b   = PRESS_SCALE;
				state_d = ST_P12;
			end
			ST_P12:  state_d = ST_P13;
			ST_P13:  if (div_done) state_d = ST_P14;
			ST_P14: begin
				mul_a   = b_q >> 3;
				mul_b   = b_q >> 3;
				state_d = ST_P15;
			end
			ST_P15: begin
				mul_a   = b_q >> 2;
				mul_b   = sext16(coef.p8);
				state_d = ST_P16;
			end
			ST_P16: begin
				mul_a   = sext16(coef.p9);
				mul_b   = c_q;
				state_d = ST_P17;
			end
			ST_P17:  state_d = ST_P18;
			ST_P18:  state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fine_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_T4) fine_q <= a_q + sra32(p_q, 14);
		end
	end

	always_ff @(posedge clk) begin
		p_q <= mul_y;
		unique case (state_q)
			ST_IDLE: begin
				adc_q     <= raw_adc;
				res_q.kind <= req_type;
			end
			ST_T0: begin
				a_q <= (adc_x >> 3) - (zext16(coef.t1) << 1);
				b_q <= (adc_x >> 4) - zext16(coef.t1);
			end
			ST_T2:  a_q <= sra32(p_q, 11);
			ST_T6: begin
				res_q.temp  <= sra32(p_q + TEMP_ROUND, 8);
				res_q.press <= '0;
			end
			ST_P0:  a_q <= sra32(fine_q, 1) - FINE_OFS;
			ST_P1:  b_q <= sra32(a_q, 2);
			ST_P3: begin
				c_q <= sra32(p_q, 11);
				d_q <= sra32(p_q, 13);
			end
			ST_P4:  e_q <= p_q << 1;
			ST_P5:  e_q <= p_q + e_q;
			ST_P6: begin
				e_q <= sra32(e_q, 2) + (sext16(coef.p4) << 16);
				c_q <= sra32(p_q, 3);
			end
			ST_P7:  a_q <= sra32(c_q + sra32(p_q, 1), 18);
			ST_P9:  a_q <= sra32(p_q, 15);
			ST_P10: begin
				c_q         <= (ADC_FULL - adc_x) - sra32(e_q, 12);
				res_q.temp  <= '0;
				res_q.press <= '0;
			end
			ST_P12: big_q <= p_q[DataW-1];
			ST_P13: b_q <= big_q ? (div_quot << 1) : div_quot;
			ST_P15: c_q <= p_q >> 13;
			ST_P16: d_q <= sra32(p_q, 13);
			ST_P17: e_q <= sra32(p_q, 12) + d_q + sext16(coef.p7);
			ST_P18: res_q.press <= b_q + sra32(e_q, 4);
			default: ;
		endcase
	end

	assign idle = (state_q == ST_IDLE);
	assign push = (state_q == ST_DONE) && out_free;
	assign res  = res_q;

endmodule
`default_nettype wire

### hw/rtl/sensor_temp_pressure_compensation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_temp_pressure_compensation: barometric sensor compensation
// Integer 32-bit temperature and pressure compensation of raw readings.
//
// Channel  Dir  Handshake                 Word
// s_axis   in   s_axis_tvalid/tready      raw reading, tuser = kind
// m_axis   out  m_axis_tvalid/tready      temperature and pressure result
// cfg      in   cfg_valid/cfg_ready       calibration register write
//
// A pressure word takes much longer than a temperature word: the 32-step
// serial divider dominates, and the shared multiplier takes one product per
// cycle. A zero divisor ends a pressure word at ST_P10, before the division.
// Reset clears calibration registers and the stored fine temperature.
// One word is in flight; a waiting result does not block the next accept.
// ----------------------------------------------------------------------------
module sensor_temp_pressure_compensation
	import stcp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [InDataW-1:0]   s_axis_tdata,   // [19:0] raw_adc, [23:20] zero
	input  logic                 s_axis_tuser,   // [0] req_type
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [OutDataW-1:0]  m_axis_tdata,   // [31:0] temperature_centi, [63:32] pressure_pa
	output logic                 m_axis_tuser,   // [0] kind
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CfgW-1:0]      cfg_data
);

	logic [CfgW-1:0] cfg_q [NumRegs];
	stcp_coef_t      coef;
	stcp_res_t       core_res;
	stcp_res_t       out_q;
	logic            out_valid_q;
	logic            core_idle, core_push, out_free, start;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) cfg_q[i] <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TEMP:    cfg_q[0] <= cfg_data;
				REG_PRESS_A: cfg_q[1] <= cfg_data;
				REG_PRESS_B: cfg_q[2] <= cfg_data;
				REG_PRESS_C: cfg_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coef.t1 = cfg_q[0][15:0];
	assign coef.t2 = cfg_q[0][31:16];
	assign coef.t3 = cfg_q[0][47:32];
	assign coef.p1 = cfg_q[1][15:0];
	assign coef.p2 = cfg_q[1][31:16];
	assign coef.p3 = cfg_q[1][47:32];
	assign coef.p4 = cfg_q[2][15:0];
	assign coef.p5 = cfg_q[2][31:16];
	assign coef.p6 = cfg_q[2][47:32];
	assign coef.p7 = cfg_q[3][15:0];
	assign coef.p8 = cfg_q[3][31:16];
	assign coef.p9 = cfg_q[3][47:32];

	assign s_axis_tready = core_idle;
	assign start         = s_axis_tvalid && core_idle;
	assign out_free      = !out_valid_q || m_axis_tready;

	stcp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (s_axis_tuser),
		.raw_adc  (s_axis_tdata[AdcW-1:0]),
		.coef     (coef),
		.out_free (out_free),
		.idle     (core_idle),
		.push     (core_push),
		.res      (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_push) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_push) out_q <= core_res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.press, out_q.temp};
	assign m_axis_tuser  = out_q.kind;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while a word is in flight");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		core_push |-> (!m_axis_tvalid || m_axis_tready) && !s_axis_tready)
		else $error("result pushed over a waiting result");

	a_temp_no_press: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == KIND_TEMP)) |-> (m_axis_tdata[63:32] == '0))
		else $error("temperature result carries a pressure value");

	a_press_no_temp: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == KIND_PRESS)) |-> (m_axis_tdata[31:0] == '0))
		else $error("pressure result carries a temperature value");

endmodule
`default_nettype wire
